[rtl/lhbq_pkg.sv]
// lhbq_pkg: shared widths, types, register indexes and saturation helpers
// for the lowpass/highpass biquad tone mix; no dependencies
package lhbq_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int STATE_BITS  = 40;
    localparam int COEF_FRAC   = COEF_BITS - 3;
    localparam int MIX_BITS    = 16;
    localparam int MIX_SHIFT   = 15;
    localparam int CFG_IDX_BITS = 3;

    // multiplier operand split: value is taken in two halves
    localparam int LO_BITS   = STATE_BITS / 2;
    localparam int HI_BITS   = STATE_BITS - LO_BITS;
    localparam int A_BITS    = COEF_BITS + 1;
    localparam int B_BITS    = HI_BITS + 1;
    localparam int PROD_BITS = A_BITS + B_BITS;
    localparam int ACC_BITS  = COEF_BITS + STATE_BITS + 4;
    localparam int RES_BITS  = COEF_BITS + STATE_BITS - COEF_FRAC + 1;
    localparam int MIX_RES_BITS = MIX_BITS + 1 + STATE_BITS + 2 - MIX_SHIFT;
    localparam int SUM_BITS  = RES_BITS + 3;

    localparam logic [MIX_BITS-1:0] MIX_ONE = MIX_BITS'(1 << MIX_SHIFT);

    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_B0   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_A1   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_A2   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_B0  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_A1  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_A2  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_MIX = 3'd6;

    typedef logic signed [SAMPLE_BITS-1:0]  t_sample;
    typedef logic signed [COEF_BITS-1:0]    t_coef;
    typedef logic signed [STATE_BITS-1:0]   t_state;
    typedef logic signed [A_BITS-1:0]       t_mac_a;
    typedef logic signed [ACC_BITS-1:0]     t_acc;
    typedef logic signed [RES_BITS-1:0]     t_res;
    typedef logic signed [MIX_RES_BITS-1:0] t_mix_res;
    typedef logic signed [SUM_BITS-1:0]     t_sum;

    // command to the shared multiply-accumulate unit
    typedef struct packed {
        logic clr;      // load rounding constant into accumulator
        logic rnd_mix;  // rounding constant for the mix scale
        logic mul;      // capture a new partial product
        logic mhi;      // partial product uses the upper half of the value
        logic acc;      // add the held partial product
    } t_mac_cmd;

    function automatic t_state f_sat_state(input t_sum v);
        t_state r;
        if ((&v[SUM_BITS-1:STATE_BITS-1]) || !(|v[SUM_BITS-1:STATE_BITS-1])) begin
            r = v[STATE_BITS-1:0];
        end else begin
            r = {v[SUM_BITS-1], {(STATE_BITS-1){~v[SUM_BITS-1]}}};
        end
        return r;
    endfunction

    function automatic t_sample f_sat_sample(input t_mix_res v);
        t_sample r;
        if ((&v[MIX_RES_BITS-1:SAMPLE_BITS-1]) || !(|v[MIX_RES_BITS-1:SAMPLE_BITS-1])) begin
            r = v[SAMPLE_BITS-1:0];
        end else begin
            r = {v[MIX_RES_BITS-1], {(SAMPLE_BITS-1){~v[MIX_RES_BITS-1]}}};
        end
        return r;
    endfunction

endpackage

[rtl/lhbq_in_if.sv]
// lhbq_in_if: valid/ready channel carrying one input audio sample per beat
// depends on lhbq_pkg
interface lhbq_in_if import lhbq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

[rtl/lhbq_out_if.sv]
// lhbq_out_if: valid/ready channel carrying one mixed output sample per beat
// depends on lhbq_pkg
interface lhbq_out_if import lhbq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/lhbq_mac.sv]
// lhbq_mac: shared multiply-accumulate unit, one 33x21 partial product a cycle
// depends on lhbq_pkg
module lhbq_mac import lhbq_pkg::*; (
    input  logic     i_clk,
    input  t_mac_cmd i_cmd,
    input  t_mac_a   i_a,
    input  t_state   i_v,
    output t_acc     o_acc
);

    logic signed [B_BITS-1:0]    w_b;
    logic signed [PROD_BITS-1:0] w_prod;
    t_acc                        w_addend;
    t_acc                        w_init;

    logic signed [PROD_BITS-1:0] r_prod;
    logic                        r_prod_hi;
    t_acc                        r_acc;

    always_comb begin
        if (i_cmd.mhi) begin
            w_b = {i_v[STATE_BITS-1], i_v[STATE_BITS-1:LO_BITS]};
        end else begin
            w_b = {1'b0, i_v[LO_BITS-1:0]};
        end
        w_prod = i_a * w_b;
        if (r_prod_hi) begin
            w_addend = ACC_BITS'(r_prod) <<< LO_BITS;
        end else begin
            w_addend = ACC_BITS'(r_prod);
        end
        if (i_cmd.rnd_mix) begin
            w_init = t_acc'(1) <<< (MIX_SHIFT - 1);
        end else begin
            w_init = t_acc'(1) <<< (COEF_FRAC - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod    <= w_prod;
            r_prod_hi <= i_cmd.mhi;
        end
        if (i_cmd.clr) begin
            r_acc <= w_init;
        end else if (i_cmd.acc) begin
            r_acc <= r_acc + w_addend;
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/lowpass_highpass_biquad_tone_mix.sv]
// lowpass_highpass_biquad_tone_mix: top level, sequencer, filter state and mix
// depends on lhbq_pkg, lhbq_in_if, lhbq_out_if, lhbq_mac
//
// Each sample beat runs through a lowpass biquad and then a highpass biquad in
// series (transposed direct form II, taps b0, +/-2*b0, b0, coefficients Q2.29)
// and leaves as a crossfade of both outputs weighted by high_mix (Q1.15, values
// above 1.0 act as 1.0), rounded and saturated to 24 bits. All arithmetic goes
// through one shared multiplier: every coefficient product is split into two
// 33x21 partial products and accumulated, and a 28-step sequencer walks the
// eight products plus the state updates. Ready stays low from the
// accepting edge until the result is loaded into the output register, and
// rises with that load, so a new beat is only taken once the previous
// sample has finished. A waiting result stalls only the last
// step. Coefficient writes go through a plain write port and must only happen
// while the block is idle; writes to index 7 are ignored.
module lowpass_highpass_biquad_tone_mix import lhbq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COEF_BITS-1:0]    i_cfg_data,
    lhbq_in_if.sink                 i_smp,
    lhbq_out_if.source              o_smp
);

    // sequencer steps; a product takes three steps and is read in the fourth
    localparam int STEP_BITS = 5;
    localparam logic [STEP_BITS-1:0] ST_LB0_LO  = 5'd0;
    localparam logic [STEP_BITS-1:0] ST_LB0_HI  = 5'd1;
    localparam logic [STEP_BITS-1:0] ST_LB0_ACC = 5'd2;
    localparam logic [STEP_BITS-1:0] ST_PL_WB   = 5'd3;
    localparam logic [STEP_BITS-1:0] ST_LY_SUM  = 5'd4;
    localparam logic [STEP_BITS-1:0] ST_LA1_LO  = 5'd5;
    localparam logic [STEP_BITS-1:0] ST_LA1_HI  = 5'd6;
    localparam logic [STEP_BITS-1:0] ST_LA1_ACC = 5'd7;
    localparam logic [STEP_BITS-1:0] ST_LA2_LO  = 5'd8;
    localparam logic [STEP_BITS-1:0] ST_LA2_HI  = 5'd9;
    localparam logic [STEP_BITS-1:0] ST_LA2_ACC = 5'd10;
    localparam logic [STEP_BITS-1:0] ST_LS1_SUM = 5'd11;
    localparam logic [STEP_BITS-1:0] ST_LS2_SUM = 5'd12;
    localparam logic [STEP_BITS-1:0] ST_HB0_ACC = 5'd13;
    localparam logic [STEP_BITS-1:0] ST_PH_WB   = 5'd14;
    localparam logic [STEP_BITS-1:0] ST_HY_SUM  = 5'd15;
    localparam logic [STEP_BITS-1:0] ST_HA1_LO  = 5'd16;
    localparam logic [STEP_BITS-1:0] ST_HA1_HI  = 5'd17;
    localparam logic [STEP_BITS-1:0] ST_HA1_ACC = 5'd18;
    localparam logic [STEP_BITS-1:0] ST_HA2_LO  = 5'd19;
    localparam logic [STEP_BITS-1:0] ST_HA2_HI  = 5'd20;
    localparam logic [STEP_BITS-1:0] ST_HA2_ACC = 5'd21;
    localparam logic [STEP_BITS-1:0] ST_HS1_SUM = 5'd22;
    localparam logic [STEP_BITS-1:0] ST_HS2_SUM = 5'd23;
    localparam logic [STEP_BITS-1:0] ST_WH_LO   = 5'd24;
    localparam logic [STEP_BITS-1:0] ST_WH_HI   = 5'd25;
    localparam logic [STEP_BITS-1:0] ST_MIX_ACC = 5'd26;
    localparam logic [STEP_BITS-1:0] ST_OUT     = 5'd27;

    // configuration registers
    t_coef               r_low_b0, r_low_a1, r_low_a2;
    t_coef               r_high_b0, r_high_a1, r_high_a2;
    logic [MIX_BITS-1:0] r_high_mix;

    // filter state words
    t_state r_ls1, r_ls2, r_hs1, r_hs2;

    // sequencer
    logic                 r_busy;
    logic [STEP_BITS-1:0] r_step;
    logic [STEP_BITS-1:0] n_step;

    // per-sample working values
    t_sample r_x;
    t_res    r_pl, r_ph, r_m1, r_m2;
    t_state  r_ly, r_hy;

    // output register
    logic    r_out_valid;
    t_sample r_out;

    logic                w_accept;
    logic                w_out_load;
    logic [MIX_BITS-1:0] w_wh, w_wl;
    t_mac_cmd            w_cmd;
    t_mac_a              w_a;
    t_state              w_v;
    t_acc                w_acc;
    t_res                w_res;
    t_mix_res            w_mix;
    t_sum                w_op_a, w_op_b, w_op_c, w_sum;
    t_state              w_sat;

    assign w_accept   = i_smp.valid && i_smp.ready;
    assign w_out_load = r_busy && (r_step == ST_OUT) && (!r_out_valid || o_smp.ready);

    // mix weights, high weight clipped at unity
    assign w_wh = (r_high_mix > MIX_ONE) ? MIX_ONE : r_high_mix;
    assign w_wl = MIX_ONE - w_wh;

    assign w_res = w_acc[COEF_FRAC +: RES_BITS];
    assign w_mix = w_acc[MIX_SHIFT +: MIX_RES_BITS];

    // step table: multiplier command and operands
    always_comb begin
        w_cmd = '0;
        w_a   = '0;
        w_v   = '0;
        if (r_busy) begin
            unique case (r_step)
                ST_LB0_LO: begin
                    w_cmd = '{clr: 1'b1, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b0, acc: 1'b0};
                    w_a   = A_BITS'(r_low_b0);
                    w_v   = STATE_BITS'(r_x);
                end
                ST_LB0_HI: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b1, acc: 1'b1};
                    w_a   = A_BITS'(r_low_b0);
                    w_v   = STATE_BITS'(r_x);
                end
                ST_LA1_LO: begin
                    w_cmd = '{clr: 1'b1, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b0, acc: 1'b0};
                    w_a   = A_BITS'(r_low_a1);
                    w_v   = r_ly;
                end
                ST_LA1_HI: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b1, acc: 1'b1};
                    w_a   = A_BITS'(r_low_a1);
                    w_v   = r_ly;
                end
                ST_LA2_LO: begin
                    w_cmd = '{clr: 1'b1, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b0, acc: 1'b0};
                    w_a   = A_BITS'(r_low_a2);
                    w_v   = r_ly;
                end
                ST_LA2_HI: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b1, acc: 1'b1};
                    w_a   = A_BITS'(r_low_a2);
                    w_v   = r_ly;
                end
                ST_LS1_SUM: begin
                    w_cmd = '{clr: 1'b1, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b0, acc: 1'b0};
                    w_a   = A_BITS'(r_high_b0);
                    w_v   = r_ly;
                end
                ST_LS2_SUM: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b1, acc: 1'b1};
                    w_a   = A_BITS'(r_high_b0);
                    w_v   = r_ly;
                end
                ST_HA1_LO: begin
                    w_cmd = '{clr: 1'b1, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b0, acc: 1'b0};
                    w_a   = A_BITS'(r_high_a1);
                    w_v   = r_hy;
                end
                ST_HA1_HI: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b1, acc: 1'b1};
                    w_a   = A_BITS'(r_high_a1);
                    w_v   = r_hy;
                end
                ST_HA2_LO: begin
                    w_cmd = '{clr: 1'b1, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b0, acc: 1'b0};
                    w_a   = A_BITS'(r_high_a2);
                    w_v   = r_hy;
                end
                ST_HA2_HI: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b1, acc: 1'b1};
                    w_a   = A_BITS'(r_high_a2);
                    w_v   = r_hy;
                end
                ST_HS1_SUM: begin
                    // start of the mix: low weight times lowpass output
                    w_cmd = '{clr: 1'b1, rnd_mix: 1'b1, mul: 1'b1, mhi: 1'b0, acc: 1'b0};
                    w_a   = A_BITS'(w_wl);
                    w_v   = r_ly;
                end
                ST_HS2_SUM: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b1, acc: 1'b1};
                    w_a   = A_BITS'(w_wl);
                    w_v   = r_ly;
                end
                ST_WH_LO: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b0, acc: 1'b1};
                    w_a   = A_BITS'(w_wh);
                    w_v   = r_hy;
                end
                ST_WH_HI: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b1, mhi: 1'b1, acc: 1'b1};
                    w_a   = A_BITS'(w_wh);
                    w_v   = r_hy;
                end
                ST_LB0_ACC, ST_LA1_ACC, ST_LA2_ACC, ST_HB0_ACC,
                ST_HA1_ACC, ST_HA2_ACC, ST_MIX_ACC: begin
                    w_cmd = '{clr: 1'b0, rnd_mix: 1'b0, mul: 1'b0, mhi: 1'b0, acc: 1'b1};
                end
                default: begin
                    w_cmd = '0;
                end
            endcase
        end
    end

    // shared adder for outputs and state updates, saturated to the state width
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        w_op_c = '0;
        unique case (r_step)
            ST_LY_SUM: begin
                w_op_a = SUM_BITS'(r_pl);
                w_op_b = SUM_BITS'(r_ls1);
            end
            ST_LS1_SUM: begin
                w_op_a = SUM_BITS'(r_pl) <<< 1;
                w_op_b = -SUM_BITS'(r_m1);
                w_op_c = SUM_BITS'(r_ls2);
            end
            ST_LS2_SUM: begin
                w_op_a = SUM_BITS'(r_pl);
                w_op_b = -SUM_BITS'(r_m2);
            end
            ST_HY_SUM: begin
                w_op_a = SUM_BITS'(r_ph);
                w_op_b = SUM_BITS'(r_hs1);
            end
            ST_HS1_SUM: begin
                // highpass middle tap is minus twice b0
                w_op_a = -(SUM_BITS'(r_ph) <<< 1);
                w_op_b = -SUM_BITS'(r_m1);
                w_op_c = SUM_BITS'(r_hs2);
            end
            ST_HS2_SUM: begin
                w_op_a = SUM_BITS'(r_ph);
                w_op_b = -SUM_BITS'(r_m2);
            end
            default: begin
                w_op_a = '0;
            end
        endcase
        w_sum = w_op_a + w_op_b + w_op_c;
        w_sat = f_sat_state(w_sum);
    end

    lhbq_mac u_mac (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .i_a   (w_a),
        .i_v   (w_v),
        .o_acc (w_acc)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_b0   <= '0;
            r_low_a1   <= '0;
            r_low_a2   <= '0;
            r_high_b0  <= '0;
            r_high_a1  <= '0;
            r_high_a2  <= '0;
            r_high_mix <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOW_B0:   r_low_b0   <= i_cfg_data;
                CFG_LOW_A1:   r_low_a1   <= i_cfg_data;
                CFG_LOW_A2:   r_low_a2   <= i_cfg_data;
                CFG_HIGH_B0:  r_high_b0  <= i_cfg_data;
                CFG_HIGH_A1:  r_high_a1  <= i_cfg_data;
                CFG_HIGH_A2:  r_high_a2  <= i_cfg_data;
                CFG_HIGH_MIX: r_high_mix <= i_cfg_data[MIX_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and output register
    always_comb begin
        n_step = r_step;
        if (w_accept) begin
            n_step = ST_LB0_LO;
        end else if (r_busy && (r_step != ST_OUT)) begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= ST_LB0_LO;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // filter state words, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls1 <= '0;
            r_ls2 <= '0;
            r_hs1 <= '0;
            r_hs2 <= '0;
        end else if (r_busy) begin
            unique case (r_step)
                ST_LS1_SUM: r_ls1 <= w_sat;
                ST_LS2_SUM: r_ls2 <= w_sat;
                ST_HS1_SUM: r_hs1 <= w_sat;
                ST_HS2_SUM: r_hs2 <= w_sat;
                default: begin
                end
            endcase
        end
    end

    // working values, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_smp.sample_in;
        end
        if (r_busy) begin
            unique case (r_step)
                ST_PL_WB:   r_pl <= w_res;
                ST_LY_SUM:  r_ly <= w_sat;
                ST_LA2_LO:  r_m1 <= w_res;
                ST_LS1_SUM: r_m2 <= w_res;
                ST_PH_WB:   r_ph <= w_res;
                ST_HY_SUM:  r_hy <= w_sat;
                ST_HA2_LO:  r_m1 <= w_res;
                ST_HS1_SUM: r_m2 <= w_res;
                default: begin
                end
            endcase
        end
        if (w_out_load) begin
            r_out <= f_sat_sample(w_mix);
        end
    end

    assign i_smp.ready      = !r_busy;
    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample_out = r_out;

    // an accepted beat starts the sequencer at its first step
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && r_step == ST_LB0_LO))
        else $error("accepted beat did not start the sequencer");

    // the last step hands the result over and frees the block
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && !r_busy))
        else $error("result load did not free the sequencer");

    // the multiplier stays quiet while idle
    a_idle_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_cmd == '0))
        else $error("multiplier command issued while idle");

    // a clear never coincides with an accumulate
    a_mac_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !(w_cmd.clr && w_cmd.acc))
        else $error("accumulator clear and add in the same cycle");

endmodule
